FILE: design/itile_pkg.sv
// Shared constants, types and helpers for the isometric tile edge renderer.
`default_nettype none

package itile_pkg;

    localparam int MAP_SIDE_DEF = 32;

    localparam int COORD_W = 8;
    localparam int BG_W    = 5;
    localparam int TILE_W  = 5;

    localparam logic [BG_W-1:0]   BG_MASK     = 5'h1F;
    localparam logic [TILE_W-1:0] SOLID_TILE  = 5'd0;
    localparam logic [TILE_W-1:0] EMPTY_TILE  = 5'd17;
    localparam logic [TILE_W-1:0] LOWER_SHIFT = 5'd8;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_DRAW  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_EW_OFFSET = 2'd0;
    localparam logic [1:0] REG_SN_OFFSET = 2'd1;
    localparam logic [1:0] REG_BG_X      = 2'd2;
    localparam logic [1:0] REG_BG_Y      = 2'd3;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Cell reads of a draw: the cell itself, then north, east, west, south.
    localparam logic [2:0] RD_CUR   = 3'd0;
    localparam logic [2:0] RD_NORTH = 3'd1;
    localparam logic [2:0] RD_EAST  = 3'd2;
    localparam logic [2:0] RD_WEST  = 3'd3;
    localparam logic [2:0] RD_SOUTH = 3'd4;
    localparam int NUM_READS = 5;

    localparam int NUM_WRITES = 8;

    typedef struct packed {
        logic rd;
        logic wr;
    } map_cmd_t;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_WR_RD   = 6'b000010,
        ST_WR_WR   = 6'b000100,
        ST_RD_ADDR = 6'b001000,
        ST_RD_BIT  = 6'b010000,
        ST_EMIT    = 6'b100000
    } state_t;

    // East-west step of each cell read.
    function automatic logic [COORD_W-1:0] ew_delta(input logic [2:0] rd);
        logic [COORD_W-1:0] d;
        d = '0;
        case (rd)
            RD_EAST: d = 8'sd1;
            RD_WEST: d = 8'hFF;
            default: d = '0;
        endcase
        return d;
    endfunction

    // South-north step of each cell read.
    function automatic logic [COORD_W-1:0] sn_delta(input logic [2:0] rd);
        logic [COORD_W-1:0] d;
        d = '0;
        case (rd)
            RD_NORTH: d = 8'hFF;
            RD_SOUTH: d = 8'sd1;
            default:  d = '0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: design/itile_if.sv
// Valid/ready channel interfaces for request words and tile write words.
`default_nettype none

interface itile_req_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic signed [itile_pkg::COORD_W-1:0] map_ew;
    logic signed [itile_pkg::COORD_W-1:0] map_sn;
    logic                                map_value;
    logic signed [itile_pkg::COORD_W-1:0] screen_x;
    logic signed [itile_pkg::COORD_W-1:0] screen_y;

    modport source (output valid, command, map_ew, map_sn, map_value, screen_x, screen_y,
                    input ready);
    modport sink (input valid, command, map_ew, map_sn, map_value, screen_x, screen_y,
                  output ready);
endinterface

interface itile_out_if;
    logic                             valid;
    logic                             ready;
    logic [itile_pkg::BG_W-1:0]       tile_col;
    logic [itile_pkg::BG_W-1:0]       tile_row;
    logic [itile_pkg::TILE_W-1:0]     tile_index;
    logic                             last;

    modport source (output valid, tile_col, tile_row, tile_index, last, input ready);
    modport sink (input valid, tile_col, tile_row, tile_index, last, output ready);
endinterface

`default_nettype wire

FILE: design/isometric_tile_edge_renderer.sv
// Isometric tile edge renderer: a write word reads its map row, then writes it back (an ignored one is only accepted).
// A draw word is accepted, then makes five cell reads through the single
// map read port (address, then bit pick), then gives 8 output words, one per cycle when taken.
// A new word is accepted only when the previous one has finished.
// Reset (rst_n low, asynchronous) empties the map via per-row valid bits and zeroes
// all offsets; no clearing pass is needed.
`default_nettype none

module isometric_tile_edge_renderer #(
    parameter int MAP_SIDE = itile_pkg::MAP_SIDE_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    itile_req_if.sink                        req,
    itile_out_if.source                      tile,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [itile_pkg::PADDR_W-1:0]    paddr,
    input  wire  [itile_pkg::PDATA_W-1:0]    pwdata,
    output logic [itile_pkg::PDATA_W-1:0]    prdata,
    output logic                             pready
);

    localparam int AW = $clog2(MAP_SIDE);
    localparam int CW = itile_pkg::COORD_W;
    localparam logic [CW-1:0] SIDE_C = CW'(MAP_SIDE);

    // Configuration registers.
    logic [CW-1:0]               ew_off_reg;
    logic [CW-1:0]               sn_off_reg;
    logic [itile_pkg::BG_W-1:0]  bg_x_reg;
    logic [itile_pkg::BG_W-1:0]  bg_y_reg;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ew_off_reg <= '0;
            sn_off_reg <= '0;
            bg_x_reg   <= '0;
            bg_y_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                itile_pkg::REG_EW_OFFSET: ew_off_reg <= pwdata[CW-1:0];
                itile_pkg::REG_SN_OFFSET: sn_off_reg <= pwdata[CW-1:0];
                itile_pkg::REG_BG_X:      bg_x_reg   <= pwdata[itile_pkg::BG_W-1:0];
                itile_pkg::REG_BG_Y:      bg_y_reg   <= pwdata[itile_pkg::BG_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            itile_pkg::REG_EW_OFFSET: prdata = {{(itile_pkg::PDATA_W-CW){1'b0}}, ew_off_reg};
            itile_pkg::REG_SN_OFFSET: prdata = {{(itile_pkg::PDATA_W-CW){1'b0}}, sn_off_reg};
            itile_pkg::REG_BG_X:
                prdata = {{(itile_pkg::PDATA_W-itile_pkg::BG_W){1'b0}}, bg_x_reg};
            itile_pkg::REG_BG_Y:
                prdata = {{(itile_pkg::PDATA_W-itile_pkg::BG_W){1'b0}}, bg_y_reg};
            default:                  prdata = '0;
        endcase
    end

    // Sequencer state.
    itile_pkg::state_t           state_reg, state_next;
    logic [2:0]                  cnt_reg, cnt_next;
    logic [CW-1:0]               ew_reg, ew_next;
    logic [CW-1:0]               sn_reg, sn_next;
    logic [AW-1:0]               col_reg, col_next;
    logic                        inr_reg, inr_next;
    logic                        val_reg, val_next;
    logic [itile_pkg::NUM_READS-1:0] cells_reg, cells_next;
    logic [itile_pkg::BG_W-1:0]  bx_reg, bx_next;
    logic [itile_pkg::BG_W-1:0]  by_reg, by_next;

    // Shared coordinate unit: base plus step plus camera offset, 8-bit wrap.
    logic [CW-1:0]               e_sum;
    logic [CW-1:0]               s_sum;
    logic                        e_in;
    logic                        s_in;

    assign e_sum = ew_reg + itile_pkg::ew_delta(cnt_reg) + ew_off_reg;
    assign s_sum = sn_reg + itile_pkg::sn_delta(cnt_reg) + sn_off_reg;
    assign e_in  = !e_sum[CW-1] && (e_sum < SIDE_C);
    assign s_in  = !s_sum[CW-1] && (s_sum < SIDE_C);

    // Write coordinate check on the incoming word.
    logic                        wr_in_range;
    assign wr_in_range = !req.map_ew[CW-1] && (req.map_ew < SIDE_C)
                      && !req.map_sn[CW-1] && (req.map_sn < SIDE_C);

    // Isometric mapping of the screen position.
    logic [CW-1:0]               sx_q;
    logic [CW-1:0]               sy_h;
    assign sx_q = CW'(req.screen_x >>> 2);
    assign sy_h = CW'(req.screen_y >>> 1);

    // Map memory.
    itile_pkg::map_cmd_t         map_cmd;
    logic [AW-1:0]               map_addr;
    logic [MAP_SIDE-1:0]         map_wdata;
    logic [MAP_SIDE-1:0]         map_rdata;

    itile_map #(
        .MAP_SIDE (MAP_SIDE),
        .AW       (AW)
    ) u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (map_cmd),
        .addr  (map_addr),
        .wdata (map_wdata),
        .rdata (map_rdata)
    );

    // Output word, computed from the held draw state and the write counter.
    logic [1:0]                  side;
    logic                        cur_cell;
    logic                        nb_cell;
    logic [itile_pkg::TILE_W-1:0] edge_idx;

    assign side     = cnt_reg[2:1];
    assign cur_cell = cells_reg[itile_pkg::RD_CUR];
    assign nb_cell  = cells_reg[3'({1'b0, side}) + 3'd1];

    always_comb
    begin
        if (cur_cell != nb_cell)
        begin
            edge_idx = 5'({side, 1'b0}) + 5'd1 + 5'(cnt_reg[0]);
            if (nb_cell)
            begin
                edge_idx = edge_idx + itile_pkg::LOWER_SHIFT;
            end
        end
        else
        begin
            edge_idx = cur_cell ? itile_pkg::SOLID_TILE : itile_pkg::EMPTY_TILE;
        end
    end

    assign tile.valid      = (state_reg == itile_pkg::ST_EMIT);
    assign tile.tile_col   = (bx_reg + 5'(cnt_reg[1:0])) & itile_pkg::BG_MASK;
    assign tile.tile_row   = (by_reg + 5'(cnt_reg[2])) & itile_pkg::BG_MASK;
    assign tile.tile_index = edge_idx;
    assign tile.last       = (cnt_reg == 3'(itile_pkg::NUM_WRITES - 1));

    assign req.ready = (state_reg == itile_pkg::ST_IDLE);

    function automatic logic [itile_pkg::BG_W-1:0] BG_W_TRUNC(input logic [CW-1:0] v);
        return v[itile_pkg::BG_W-1:0];
    endfunction

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ew_next    = ew_reg;
        sn_next    = sn_reg;
        col_next   = col_reg;
        inr_next   = inr_reg;
        val_next   = val_reg;
        cells_next = cells_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        map_cmd    = '0;
        map_addr   = s_sum[AW-1:0];
        map_wdata  = map_rdata;

        unique case (state_reg)
            itile_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.command == itile_pkg::CMD_WRITE)
                    begin
                        col_next = req.map_ew[AW-1:0];
                        sn_next  = req.map_sn;
                        val_next = req.map_value;
                        if (wr_in_range)
                        begin
                            state_next = itile_pkg::ST_WR_RD;
                        end
                    end
                    else
                    begin
                        ew_next    = sx_q - sy_h;
                        sn_next    = sx_q + sy_h;
                        bx_next    = BG_W_TRUNC(req.screen_x) + bg_x_reg;
                        by_next    = BG_W_TRUNC(req.screen_y) + bg_y_reg;
                        cnt_next   = itile_pkg::RD_CUR;
                        state_next = itile_pkg::ST_RD_ADDR;
                    end
                end
            end
            itile_pkg::ST_WR_RD:
            begin
                map_cmd.rd = 1'b1;
                map_addr   = sn_reg[AW-1:0];
                state_next = itile_pkg::ST_WR_WR;
            end
            itile_pkg::ST_WR_WR:
            begin
                map_cmd.wr         = 1'b1;
                map_addr           = sn_reg[AW-1:0];
                map_wdata[col_reg] = val_reg;
                state_next         = itile_pkg::ST_IDLE;
            end
            itile_pkg::ST_RD_ADDR:
            begin
                map_cmd.rd = 1'b1;
                map_addr   = s_sum[AW-1:0];
                col_next   = e_sum[AW-1:0];
                inr_next   = e_in && s_in;
                state_next = itile_pkg::ST_RD_BIT;
            end
            itile_pkg::ST_RD_BIT:
            begin
                cells_next[cnt_reg] = inr_reg && map_rdata[col_reg];
                if (cnt_reg == itile_pkg::RD_SOUTH)
                begin
                    cnt_next   = '0;
                    state_next = itile_pkg::ST_EMIT;
                end
                else
                begin
                    cnt_next   = cnt_reg + 3'd1;
                    state_next = itile_pkg::ST_RD_ADDR;
                end
            end
            itile_pkg::ST_EMIT:
            begin
                if (tile.ready)
                begin
                    cnt_next = cnt_reg + 3'd1;
                    if (tile.last)
                    begin
                        state_next = itile_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = itile_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itile_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ew_reg    <= ew_next;
        sn_reg    <= sn_next;
        col_reg   <= col_next;
        inr_reg   <= inr_next;
        val_reg   <= val_next;
        cells_reg <= cells_next;
        bx_reg    <= bx_next;
        by_reg    <= by_next;
    end

endmodule

`default_nettype wire

FILE: design/itile_map.sv
// Solidity map storage: one row per word, per-row valid bits cleared at reset.
`default_nettype none

module itile_map #(
    parameter int MAP_SIDE = itile_pkg::MAP_SIDE_DEF,
    parameter int AW       = $clog2(MAP_SIDE)
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire itile_pkg::map_cmd_t cmd,
    input  wire  [AW-1:0]           addr,
    input  wire  [MAP_SIDE-1:0]     wdata,
    output logic [MAP_SIDE-1:0]     rdata
);

    logic [MAP_SIDE-1:0] mem [MAP_SIDE];
    logic [MAP_SIDE-1:0] row_valid_reg;
    logic [MAP_SIDE-1:0] rdata_reg;
    logic                rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.wr)
            begin
                row_valid_reg[addr] <= 1'b1;
            end
            if (cmd.rd)
            begin
                rvalid_reg <= row_valid_reg[addr];
            end
        end
    end

    // A row never written since reset reads as all empty.
    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

`default_nettype wire

FILE: tb/sv/isometric_tile_edge_renderer_tb.sv
// Testbench for the isometric tile edge renderer: directed and random map and draw words.
`default_nettype none

module isometric_tile_edge_renderer_tb;
    import itile_pkg::*;

    typedef struct packed {
        logic [BG_W-1:0]   col;
        logic [BG_W-1:0]   row;
        logic [TILE_W-1:0] index;
        logic              last;
    } tile_word_t;

    logic clk = 1'b0;
    logic rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    itile_req_if req_ch ();
    itile_out_if tile_ch ();

    isometric_tile_edge_renderer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .tile    (tile_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Local copy of the solidity map (row = south-north, bit = east-west) and of the registers.
    logic [31:0]       solid_rows [32];
    logic [7:0]        cam_ew;
    logic [7:0]        cam_sn;
    logic [BG_W-1:0]   bg_x;
    logic [BG_W-1:0]   bg_y;

    tile_word_t tile_writes_due [$];
    int error_count = 0;
    int idle_pct = 28;
    int stall_pct = 28;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        tile_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic cell_bit(input logic [7:0] ew, input logic [7:0] sn);
        logic [7:0] e;
        logic [7:0] s;
        e = ew + cam_ew;
        s = sn + cam_sn;
        if (e[7:5] != 3'b000 || s[7:5] != 3'b000)
            return 1'b0;
        return solid_rows[s[4:0]][e[4:0]];
    endfunction

    // Applies one accepted word to the local map, or queues the eight tile writes of a draw.
    task automatic predict_word(input logic cmd, input logic signed [7:0] map_ew,
                                input logic signed [7:0] map_sn, input logic value,
                                input logic signed [7:0] sx, input logic signed [7:0] sy);
        logic [7:0]      ew;
        logic [7:0]      sn;
        logic            cur;
        logic [3:0]      nb;
        logic [BG_W-1:0] bx;
        logic [BG_W-1:0] by;
        tile_word_t      w;
        int              k;
        int              side;
        if (cmd == CMD_WRITE)
        begin
            if (map_ew[7:5] == 3'b000 && map_sn[7:5] == 3'b000)
                solid_rows[map_sn[4:0]][map_ew[4:0]] = value;
        end
        else
        begin
            ew = (sx >>> 2) - (sy >>> 1);
            sn = (sx >>> 2) + (sy >>> 1);
            cur = cell_bit(ew, sn);
            nb[0] = cell_bit(ew, sn - 8'd1);
            nb[1] = cell_bit(ew + 8'd1, sn);
            nb[2] = cell_bit(ew - 8'd1, sn);
            nb[3] = cell_bit(ew, sn + 8'd1);
            bx = sx[4:0] + bg_x;
            by = sy[4:0] + bg_y;
            for (k = 0; k < NUM_WRITES; k++)
            begin
                side = k >> 1;
                if (cur != nb[side])
                begin
                    w.index = TILE_W'(2 * side + 1 + (k & 1));
                    if (!cur)
                        w.index = w.index + LOWER_SHIFT;
                end
                else
                begin
                    w.index = cur ? SOLID_TILE : EMPTY_TILE;
                end
                w.col = bx + BG_W'(k & 3);
                w.row = by + BG_W'(k >> 2);
                w.last = (k == NUM_WRITES - 1);
                tile_writes_due.push_back(w);
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        tile_word_t want;
        if (rst_n === 1'b1 && tile_ch.valid === 1'b1 && tile_ch.ready === 1'b1)
        begin
            if (tile_writes_due.size() == 0)
            begin
                $error("tile word with none expected: col %0d row %0d index %0d last %0d",
                       tile_ch.tile_col, tile_ch.tile_row, tile_ch.tile_index, tile_ch.last);
                error_count++;
            end
            else
            begin
                want = tile_writes_due.pop_front();
                check_field("tile_col", want.col, tile_ch.tile_col);
                check_field("tile_row", want.row, tile_ch.tile_row);
                check_field("tile_index", want.index, tile_ch.tile_index);
                check_field("last", want.last, tile_ch.last);
            end
        end
    end

    // Sends one request word; valid stays high after acceptance until the next idle or pause.
    task automatic send_word(input logic cmd, input logic [7:0] map_ew, input logic [7:0] map_sn,
                             input logic value, input logic [7:0] sx, input logic [7:0] sy);
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.command   <= cmd;
        req_ch.map_ew    <= map_ew;
        req_ch.map_sn    <= map_sn;
        req_ch.map_value <= value;
        req_ch.screen_x  <= sx;
        req_ch.screen_y  <= sy;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        predict_word(cmd, map_ew, map_sn, value, sx, sy);
    endtask

    task automatic put_cell(input logic [7:0] ew, input logic [7:0] sn, input logic value);
        send_word(CMD_WRITE, ew, sn, value, 8'($urandom()), 8'($urandom()));
    endtask

    task automatic draw_at(input logic [7:0] sx, input logic [7:0] sy);
        send_word(CMD_DRAW, 8'($urandom()), 8'($urandom()), 1'($urandom()), sx, sy);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (tile_writes_due.size() != 0)
            @(posedge clk);
    endtask

    // A map write leaves no result behind, so give the block time to finish it as well.
    task automatic settle();
        wait_drained();
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        logic [31:0] data;
        data = $urandom();
        if (idx == REG_EW_OFFSET || idx == REG_SN_OFFSET)
            data[7:0] = value;
        else
            data[4:0] = value[4:0];
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_EW_OFFSET: cam_ew = data[7:0];
            REG_SN_OFFSET: cam_sn = data[7:0];
            REG_BG_X:      bg_x = data[4:0];
            REG_BG_Y:      bg_y = data[4:0];
            default:       ;
        endcase
    endtask

    task automatic set_camera(input logic [7:0] ew, input logic [7:0] sn,
                              input logic [4:0] bgx, input logic [4:0] bgy);
        settle();
        write_reg(REG_EW_OFFSET, ew);
        write_reg(REG_SN_OFFSET, sn);
        write_reg(REG_BG_X, {3'b000, bgx});
        write_reg(REG_BG_Y, {3'b000, bgy});
    endtask

    // Fresh map and reset offsets: every draw sees empty cells only.
    task automatic test_empty_map();
        draw_at(8'sd0, 8'sd0);
        draw_at(-8'sd128, -8'sd128);
        draw_at(8'sd127, 8'sd127);
        draw_at(-8'sd128, 8'sd127);
    endtask

    // Raised, lowered and solid edges, ignored writes and clearing of a cell.
    task automatic test_cell_edges();
        put_cell(8'd0, 8'd0, 1'b1);
        put_cell(8'd31, 8'd31, 1'b1);
        put_cell(8'd31, 8'd30, 1'b1);
        put_cell(8'd6, 8'd5, 1'b1);
        put_cell(8'd5, 8'd5, 1'b1);
        put_cell(-8'sd1, 8'd5, 1'b1);
        put_cell(8'd32, 8'd5, 1'b1);
        put_cell(8'd5, -8'sd128, 1'b1);
        put_cell(8'd127, 8'd127, 1'b1);
        draw_at(8'sd0, 8'sd0);
        draw_at(8'sd124, 8'sd0);
        draw_at(8'sd20, -8'sd2);
        draw_at(8'sd20, 8'sd0);
        draw_at(8'sd72, -8'sd26);
        put_cell(8'd5, 8'd5, 1'b0);
        draw_at(8'sd20, 8'sd0);
    endtask

    // Camera and background offsets at their extremes, then one that lands on a solid cell.
    task automatic test_camera_extremes();
        set_camera(8'sd127, -8'sd128, 5'd31, 5'd31);
        draw_at(-8'sd128, -8'sd128);
        draw_at(8'sd127, 8'sd127);
        set_camera(-8'sd128, 8'sd127, 5'd0, 5'd31);
        draw_at(-8'sd1, -8'sd1);
        set_camera(8'sd1, 8'sd0, 5'd31, 5'd0);
        draw_at(8'sd20, 8'sd0);
    endtask

    task automatic random_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            if ($urandom_range(9) == 0)
                put_cell(8'($urandom()), 8'($urandom()), 1'($urandom()));
            else
                put_cell(8'($urandom_range(31)), 8'($urandom_range(31)), 1'($urandom()));
        end
        else if (pick < 90)
        begin
            // Screen positions that map onto the map and just around it.
            draw_at(8'($urandom_range(127)), 8'($urandom_range(127)) - 8'd64);
        end
        else
        begin
            send_word(CMD_DRAW, 8'($urandom()), 8'($urandom()), 1'($urandom()),
                      8'($urandom()), 8'($urandom()));
        end
    endtask

    task automatic test_random_traffic();
        int i;
        set_camera(8'd0, 8'd0, 5'($urandom()), 5'($urandom()));
        for (i = 0; i < 35; i++)
            random_word();
        set_camera(8'($urandom_range(6)) - 8'd3, 8'($urandom_range(6)) - 8'd3, 5'd31, 5'd0);
        idle_pct = 0;
        stall_pct = 0;
        for (i = 0; i < 30; i++)
            random_word();
        idle_pct = 28;
        stall_pct = 28;
        set_camera(8'($urandom_range(12)) - 8'd6, 8'($urandom_range(12)) - 8'd6,
                   5'($urandom()), 5'($urandom()));
        for (i = 0; i < 20; i++)
            random_word();
        wait_drained();
        for (i = 0; i < 20; i++)
            random_word();
    endtask

    initial
    begin
        int waited;
        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.command   <= CMD_WRITE;
        req_ch.map_ew    <= '0;
        req_ch.map_sn    <= '0;
        req_ch.map_value <= 1'b0;
        req_ch.screen_x  <= '0;
        req_ch.screen_y  <= '0;
        for (int r = 0; r < 32; r++)
            solid_rows[r] = '0;
        cam_ew = '0;
        cam_sn = '0;
        bg_x = '0;
        bg_y = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_map();
        test_cell_edges();
        test_camera_extremes();
        test_random_traffic();

        req_ch.valid <= 1'b0;
        waited = 0;
        while (tile_writes_due.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        if (tile_writes_due.size() != 0)
        begin
            $error("%0d tile words never arrived", tile_writes_due.size());
            error_count++;
        end
        if (error_count == 0)
            $display("isometric_tile_edge_renderer_tb OK");
        else
            $display("isometric_tile_edge_renderer_tb NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("isometric_tile_edge_renderer_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
design/itile_pkg.sv
design/itile_if.sv
design/itile_map.sv
design/isometric_tile_edge_renderer.sv
tb/sv/isometric_tile_edge_renderer_tb.sv
